// ===== hdl/arpc_pkg.sv =====
// Shared constants, request codes and controller/datapath interface types for the ARP cache.
package arpc_pkg;

    // Table geometry.
    localparam int TABLE_ENTRIES = 16;
    localparam int SLOT_W        = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

    // Field widths.
    localparam int REQ_W      = 2;
    localparam int IP_W       = 32;
    localparam int MAC_W      = 48;
    localparam int OUT_SLOT_W = 4;

    // Stream payload widths, padded to whole bytes.
    localparam int S_DATA_W = ((IP_W + MAC_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((MAC_W + OUT_SLOT_W + 7) / 8) * 8;

    // Request codes.
    typedef enum logic [REQ_W-1:0] {
        REQ_LOOKUP = 2'd0,
        REQ_INSERT = 2'd1,
        REQ_CLEAR  = 2'd2
    } t_req_type;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;   // take the input transfer into the request registers
        logic rd_issue;  // read the entry at the scan counter, advance the counter
        logic scan_next; // advance the counter during the free-slot search
        logic ins_write; // write the request into the table
        logic ins_zero;  // the write goes to slot 0 (table full)
        logic set_hit;   // take the last read entry as the lookup result
        logic clear_all; // drop every valid mark
        logic load_out;  // move the result into the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_req_type req;       // captured request code
        logic      cnt_end;   // scan counter has passed the last slot
        logic      slot_free; // slot at the scan counter is not valid
        logic      scan_last; // scan counter is at the last slot
        logic      hit;       // last read entry is valid and matches
        logic      rd_last;   // last read entry was the last slot
        logic      out_free;  // output register can take a result this cycle
    } t_status;

endpackage

// ===== hdl/arpc_ctrl.sv =====
// Controller state machine that sequences lookups, inserts and clears.
module arpc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  arpc_pkg::t_status i_status,
    output arpc_pkg::t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISP,
        ST_LOOK,
        ST_FIND,
        ST_FIN
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and datapath commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_DISP;
                end
            end
            ST_DISP: begin
                unique case (i_status.req)
                    arpc_pkg::REQ_LOOKUP: n_state = ST_LOOK;
                    arpc_pkg::REQ_INSERT: n_state = ST_FIND;
                    arpc_pkg::REQ_CLEAR: begin
                        o_cmd.clear_all = 1'b1;
                        n_state         = ST_FIN;
                    end
                    default: n_state = ST_FIN;
                endcase
            end
            ST_LOOK: begin
                // Reads are issued one slot a cycle; each is compared in the following cycle.
                o_cmd.rd_issue = !i_status.cnt_end;
                if (i_status.hit) begin
                    o_cmd.set_hit = 1'b1;
                    n_state       = ST_FIN;
                end else if (i_status.rd_last) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIND: begin
                if (i_status.slot_free) begin
                    o_cmd.ins_write = 1'b1;
                    n_state         = ST_FIN;
                end else if (i_status.scan_last) begin
                    o_cmd.ins_write = 1'b1;
                    o_cmd.ins_zero  = 1'b1;
                    n_state         = ST_FIN;
                end else begin
                    o_cmd.scan_next = 1'b1;
                end
            end
            ST_FIN: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);

endmodule

// ===== hdl/arpc_dp.sv =====
// Datapath: request registers, valid bits, address table, scan counter and output register.
module arpc_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [arpc_pkg::REQ_W-1:0]        i_req_type,
    input  logic [arpc_pkg::IP_W-1:0]         i_ip_addr,
    input  logic [arpc_pkg::MAC_W-1:0]        i_mac_addr,
    input  arpc_pkg::t_cmd                    i_cmd,
    output arpc_pkg::t_status                 o_status,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic                              o_found,
    output logic [arpc_pkg::MAC_W-1:0]        o_mac_result,
    output logic [arpc_pkg::OUT_SLOT_W-1:0]   o_slot_index
);

    localparam int N = arpc_pkg::TABLE_ENTRIES;

    // Captured request.
    arpc_pkg::t_req_type               r_req;
    logic [arpc_pkg::IP_W-1:0]         r_ip;
    logic [arpc_pkg::MAC_W-1:0]        r_mac;

    // Table storage.
    logic [N-1:0]                      r_valid;
    logic [arpc_pkg::IP_W-1:0]         r_mem_ip  [N];
    logic [arpc_pkg::MAC_W-1:0]        r_mem_mac [N];

    // Scan counter and read stage.
    logic [arpc_pkg::CNT_W-1:0]        r_cnt;
    logic [arpc_pkg::SLOT_W-1:0]       cnt_idx;
    logic                              r_rd_live;
    logic                              r_rd_vld;
    logic [arpc_pkg::SLOT_W-1:0]       r_rd_slot;
    logic [arpc_pkg::IP_W-1:0]         r_rd_ip;
    logic [arpc_pkg::MAC_W-1:0]        r_rd_mac;

    // Working result and output register.
    logic                              r_w_found;
    logic [arpc_pkg::MAC_W-1:0]        r_w_mac;
    logic [arpc_pkg::SLOT_W-1:0]       r_w_slot;
    logic                              r_out_valid;
    logic                              r_out_found;
    logic [arpc_pkg::MAC_W-1:0]        r_out_mac;
    logic [arpc_pkg::OUT_SLOT_W-1:0]   r_out_slot;

    logic [arpc_pkg::SLOT_W-1:0]       wr_addr;
    logic [arpc_pkg::SLOT_W+arpc_pkg::OUT_SLOT_W-1:0] slot_ext;
    logic                              out_free;

    assign cnt_idx  = r_cnt[arpc_pkg::SLOT_W-1:0];
    assign wr_addr  = i_cmd.ins_zero ? '0 : cnt_idx;
    assign out_free = !r_out_valid || i_out_ready;
    assign slot_ext = {{arpc_pkg::OUT_SLOT_W{1'b0}}, r_w_slot};

    // Status toward the controller.
    always_comb begin
        o_status.req       = r_req;
        o_status.cnt_end   = (r_cnt == arpc_pkg::CNT_W'(N));
        o_status.slot_free = !r_valid[cnt_idx];
        o_status.scan_last = (cnt_idx == arpc_pkg::SLOT_W'(N - 1));
        o_status.hit       = r_rd_live && r_rd_vld && (r_rd_ip == r_ip);
        o_status.rd_last   = r_rd_live && (r_rd_slot == arpc_pkg::SLOT_W'(N - 1));
        o_status.out_free  = out_free;
    end

    // Request registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req <= arpc_pkg::t_req_type'(i_req_type);
            r_ip  <= i_ip_addr;
            r_mac <= i_mac_addr;
        end
    end

    // Address table: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.ins_write) begin
            r_mem_ip[wr_addr]  <= r_ip;
            r_mem_mac[wr_addr] <= r_mac;
        end
        r_rd_ip   <= r_mem_ip[cnt_idx];
        r_rd_mac  <= r_mem_mac[cnt_idx];
        r_rd_vld  <= r_valid[cnt_idx];
        r_rd_slot <= cnt_idx;
    end

    // Valid marks, scan counter and read tracking.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_cnt     <= '0;
            r_rd_live <= 1'b0;
        end else begin
            r_rd_live <= i_cmd.rd_issue;
            if (i_cmd.clear_all) begin
                r_valid <= '0;
            end else if (i_cmd.ins_write) begin
                r_valid[wr_addr] <= 1'b1;
            end
            if (i_cmd.capture) begin
                r_cnt <= '0;
            end else if (i_cmd.rd_issue || i_cmd.scan_next) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // Working result.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_w_found <= 1'b0;
            r_w_mac   <= '0;
            r_w_slot  <= '0;
        end else if (i_cmd.set_hit) begin
            r_w_found <= 1'b1;
            r_w_mac   <= r_rd_mac;
            r_w_slot  <= r_rd_slot;
        end else if (i_cmd.ins_write) begin
            r_w_slot <= wr_addr;
        end
    end

    // Output register; holds its result until the transfer completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_found <= r_w_found;
            r_out_mac   <= r_w_mac;
            r_out_slot  <= slot_ext[arpc_pkg::OUT_SLOT_W-1:0];
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_found      = r_out_found;
    assign o_mac_result = r_out_mac;
    assign o_slot_index = r_out_slot;

    // A new result never overwrites one that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> out_free)
        else $error("result loaded while output register is occupied");

    // An insert leaves its slot marked valid.
    a_insert_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ins_write && !i_cmd.clear_all |=> r_valid[$past(wr_addr)])
        else $error("inserted slot not marked valid");

    // A clear drops every valid mark.
    a_clear_all: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear_all |=> (r_valid == '0))
        else $error("valid marks remain after clear");

    // Reads are never issued past the last slot.
    a_read_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_issue |-> (r_cnt < arpc_pkg::CNT_W'(N)))
        else $error("table read beyond the last slot");

endmodule

// ===== hdl/arp_cache_table_unit.sv =====
// Top level of the ARP cache: stream ports, controller and datapath.
//
// The slave stream carries one request per transfer: s_axis_tuser holds the
// request code (lookup, insert, clear) and s_axis_tdata the IPv4 and MAC
// addresses. Every request gives exactly one result transfer on the master
// stream: m_axis_tuser is the hit flag, m_axis_tdata the matched MAC and the
// slot number.
// Requests are handled one at a time. A lookup reads the table one slot per
// cycle through a registered read port and stops at the first valid match.
// An insert scans the valid marks one slot per cycle for the lowest free
// slot. The result sits in an output register; the next request is taken
// while it waits. If the receiver stalls, the following request finishes its
// scan and then waits until the output register is free.
// Reset clears all valid marks, so the table is usable at once; stored
// addresses are not cleared and are never used before they are written.
module arp_cache_table_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Request channel.
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [arpc_pkg::S_DATA_W-1:0]     s_axis_tdata,  // ip_addr[31:0], mac_addr[79:32]
    input  logic [arpc_pkg::REQ_W-1:0]        s_axis_tuser,  // req_type[1:0]
    // Result channel.
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [arpc_pkg::M_DATA_W-1:0]     m_axis_tdata,  // mac_result[47:0], slot_index[51:48]
    output logic                              m_axis_tuser   // found[0]
);

    arpc_pkg::t_cmd                    cmd;
    arpc_pkg::t_status                 status;
    logic                              found;
    logic [arpc_pkg::MAC_W-1:0]        mac_result;
    logic [arpc_pkg::OUT_SLOT_W-1:0]   slot_index;

    // Sequencing.
    arpc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Storage and result path.
    arpc_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_type   (s_axis_tuser),
        .i_ip_addr    (s_axis_tdata[arpc_pkg::IP_W-1:0]),
        .i_mac_addr   (s_axis_tdata[arpc_pkg::IP_W+arpc_pkg::MAC_W-1:arpc_pkg::IP_W]),
        .i_cmd        (cmd),
        .o_status     (status),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_found      (found),
        .o_mac_result (mac_result),
        .o_slot_index (slot_index)
    );

    // Pack the result transfer.
    assign m_axis_tuser = found;
    assign m_axis_tdata = {{(arpc_pkg::M_DATA_W - arpc_pkg::MAC_W - arpc_pkg::OUT_SLOT_W){1'b0}},
                           slot_index, mac_result};

endmodule

// ===== test/arp_cache_checker.sv =====
`timescale 1ns / 1ps
// Checker for the ARP cache table: tracks the table, predicts each result and compares it.
module arp_cache_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Request channel, observed.
    input  logic                          i_s_tvalid,
    input  logic                          i_s_tready,
    input  logic [arpc_pkg::S_DATA_W-1:0] i_s_tdata,   // ip_addr[31:0], mac_addr[79:32]
    input  logic [arpc_pkg::REQ_W-1:0]    i_s_tuser,   // req_type[1:0]
    // Result channel, observed.
    input  logic                          i_m_tvalid,
    input  logic                          i_m_tready,
    input  logic [arpc_pkg::M_DATA_W-1:0] i_m_tdata,   // mac_result[47:0], slot_index[51:48]
    input  logic                          i_m_tuser,   // found[0]
    // Run statistics for the testbench top.
    output int                            o_errors,
    output int                            o_pending,
    output int                            o_checked,
    output int                            o_hits,
    output int                            o_full_inserts
);

    typedef struct packed {
        logic                            found;
        logic [arpc_pkg::MAC_W-1:0]      mac;
        logic [arpc_pkg::OUT_SLOT_W-1:0] slot;
    } t_arp_result;

    // Shadow copy of the table.
    logic                       slot_valid [arpc_pkg::TABLE_ENTRIES];
    logic [arpc_pkg::IP_W-1:0]  slot_ip    [arpc_pkg::TABLE_ENTRIES];
    logic [arpc_pkg::MAC_W-1:0] slot_mac   [arpc_pkg::TABLE_ENTRIES];

    // Results still owed by the block, oldest first.
    t_arp_result expected_results [$];

    // Apply one request to the shadow table and return the result it must produce.
    function automatic t_arp_result resolve_request(input logic [arpc_pkg::REQ_W-1:0] code,
                                                    input logic [arpc_pkg::IP_W-1:0] ip,
                                                    input logic [arpc_pkg::MAC_W-1:0] mac,
                                                    output bit was_full);
        t_arp_result res;
        int          target;
        res      = '0;
        target   = 0;
        was_full = 1'b1;
        case (code)
            arpc_pkg::REQ_LOOKUP: begin
                // Scan downward so that the lowest matching slot is the one kept.
                for (int i = arpc_pkg::TABLE_ENTRIES - 1; i >= 0; i--) begin
                    if (slot_valid[i] && slot_ip[i] == ip) begin
                        res.found = 1'b1;
                        res.mac   = slot_mac[i];
                        res.slot  = arpc_pkg::OUT_SLOT_W'(i);
                    end
                end
                was_full = 1'b0;
            end
            arpc_pkg::REQ_INSERT: begin
                // Lowest free slot; slot 0 when the table is full.
                for (int i = arpc_pkg::TABLE_ENTRIES - 1; i >= 0; i--) begin
                    if (!slot_valid[i]) begin
                        target   = i;
                        was_full = 1'b0;
                    end
                end
                slot_valid[target] = 1'b1;
                slot_ip[target]    = ip;
                slot_mac[target]   = mac;
                res.slot           = arpc_pkg::OUT_SLOT_W'(target);
            end
            arpc_pkg::REQ_CLEAR: begin
                for (int i = 0; i < arpc_pkg::TABLE_ENTRIES; i++) slot_valid[i] = 1'b0;
                was_full = 1'b0;
            end
            default: begin
                // The unused request code leaves the table alone.
                was_full = 1'b0;
            end
        endcase
        return res;
    endfunction

    // Watch both channels at every edge; results are matched before new requests are added.
    always @(posedge i_clk) begin : monitor
        t_arp_result want;
        t_arp_result got;
        bit          was_full;
        int          errs;
        errs = 0;
        if (!i_rst_n) begin
            for (int i = 0; i < arpc_pkg::TABLE_ENTRIES; i++) slot_valid[i] = 1'b0;
            expected_results.delete();
            o_errors       <= 0;
            o_pending      <= 0;
            o_checked      <= 0;
            o_hits         <= 0;
            o_full_inserts <= 0;
        end else begin
            // Result transfer: compare with the oldest prediction.
            if (i_m_tvalid && i_m_tready) begin
                got.found = i_m_tuser;
                got.mac   = i_m_tdata[arpc_pkg::MAC_W-1:0];
                got.slot  = i_m_tdata[arpc_pkg::MAC_W+arpc_pkg::OUT_SLOT_W-1:arpc_pkg::MAC_W];
                if (expected_results.size() == 0) begin
                    $error("Result transfer with no request outstanding: %s %0d, %s %h, %s %0d",
                           "found", got.found, "mac_result", got.mac, "slot_index", got.slot);
                    errs++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.found !== want.found) begin
                        $error("found: expected %0d, actual %0d", want.found, got.found);
                        errs++;
                    end
                    if (got.mac !== want.mac) begin
                        $error("mac_result: expected %h, actual %h", want.mac, got.mac);
                        errs++;
                    end
                    if (got.slot !== want.slot) begin
                        $error("slot_index: expected %0d, actual %0d", want.slot, got.slot);
                        errs++;
                    end
                    o_checked <= o_checked + 1;
                    if (want.found) o_hits <= o_hits + 1;
                end
            end
            // Request transfer: update the table and queue the result it owes.
            if (i_s_tvalid && i_s_tready) begin
                want = resolve_request(i_s_tuser, i_s_tdata[arpc_pkg::IP_W-1:0],
                                       i_s_tdata[arpc_pkg::IP_W+arpc_pkg::MAC_W-1:arpc_pkg::IP_W],
                                       was_full);
                expected_results.push_back(want);
                if (was_full) o_full_inserts <= o_full_inserts + 1;
            end
            o_pending <= expected_results.size();
            o_errors  <= o_errors + errs;
        end
    end

endmodule

// ===== test/tb_arp_cache_table_unit.sv =====
`timescale 1ns / 1ps
// Testbench top for the ARP cache table: clock, reset, request stimulus, receiver and verdict.
module tb_arp_cache_table_unit;

    // The request code that the block must ignore.
    localparam logic [arpc_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 830;
    localparam int POOL_SIZE    = 20;
    localparam int IDLE_LIMIT   = 4000;

    logic                          i_clk         = 1'b0;
    logic                          i_rst_n       = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [arpc_pkg::S_DATA_W-1:0] s_axis_tdata  = '0;   // ip_addr[31:0], mac_addr[79:32]
    logic [arpc_pkg::REQ_W-1:0]    s_axis_tuser  = '0;   // req_type[1:0]
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [arpc_pkg::M_DATA_W-1:0] m_axis_tdata;         // mac_result[47:0], slot_index[51:48]
    logic                          m_axis_tuser;         // found[0]

    int errors;
    int pending;
    int checked;
    int hits;
    int full_inserts;
    int sent        = 0;
    int idle_cycles = 0;
    int rx_wait     = 0;
    bit tx_burst    = 1'b0;
    bit rx_fast     = 1'b0;

    logic [arpc_pkg::IP_W-1:0] ip_pool [POOL_SIZE];

    arp_cache_table_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    arp_cache_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_tvalid     (s_axis_tvalid),
        .i_s_tready     (s_axis_tready),
        .i_s_tdata      (s_axis_tdata),
        .i_s_tuser      (s_axis_tuser),
        .i_m_tvalid     (m_axis_tvalid),
        .i_m_tready     (m_axis_tready),
        .i_m_tdata      (m_axis_tdata),
        .i_m_tuser      (m_axis_tuser),
        .o_errors       (errors),
        .o_pending      (pending),
        .o_checked      (checked),
        .o_hits         (hits),
        .o_full_inserts (full_inserts)
    );

    // 8 ns clock.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Receiver: after each result transfer, stall for a random number of cycles.
    always @(posedge i_clk) begin : receiver
        int stall;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_wait       <= 0;
            rx_fast       <= 1'b0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            stall = rx_fast ? 0 : $urandom_range(0, 19);
            m_axis_tready <= (stall == 0);
            rx_wait       <= stall;
            if ($urandom_range(0, 39) == 0) rx_fast <= !rx_fast;
        end else if (rx_wait > 1) begin
            rx_wait <= rx_wait - 1;
        end else begin
            rx_wait       <= 0;
            m_axis_tready <= 1'b1;
        end
    end

    // Watchdog: end the run if nothing moves on either channel for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
            $display("Verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [arpc_pkg::MAC_W-1:0] random_mac();
        return arpc_pkg::MAC_W'({$urandom, $urandom});
    endfunction

    // Present one request after a random gap and hold it until it is taken.
    task automatic send_request(input logic [arpc_pkg::REQ_W-1:0] code,
                                input logic [arpc_pkg::IP_W-1:0] ip,
                                input logic [arpc_pkg::MAC_W-1:0] mac);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= code;
        s_axis_tdata  <= {mac, ip};
        do @(posedge i_clk); while (!s_axis_tready);
        sent++;
    endtask

    // Stop sending until every outstanding result has been received.
    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin : stimulus
        logic [arpc_pkg::IP_W-1:0]  ip;
        logic [arpc_pkg::MAC_W-1:0] mac;
        int                         pick;
        logic [arpc_pkg::REQ_W-1:0] code;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: empty-table miss, fill with extremes and a duplicate address.
        send_request(arpc_pkg::REQ_LOOKUP, '0, '1);
        for (int i = 0; i < arpc_pkg::TABLE_ENTRIES; i++) begin
            if (i == 0 || i == 5) ip = '0;
            else if (i == arpc_pkg::TABLE_ENTRIES - 1) ip = '1;
            else ip = {8'd192, 8'd168, 8'd1, 8'(i)};
            if (i == 0) mac = '1;
            else if (i == arpc_pkg::TABLE_ENTRIES - 1) mac = '0;
            else mac = random_mac();
            send_request(arpc_pkg::REQ_INSERT, ip, mac);
        end
        // Insert into a full table overwrites slot 0.
        send_request(arpc_pkg::REQ_INSERT, 32'h0A00_0001, random_mac());
        // Duplicate address now hits its remaining copy in slot 5, then the all-ones address and the new slot 0.
        send_request(arpc_pkg::REQ_LOOKUP, '0, random_mac());
        send_request(arpc_pkg::REQ_LOOKUP, '1, random_mac());
        send_request(arpc_pkg::REQ_LOOKUP, 32'h0A00_0001, random_mac());
        send_request(REQ_UNUSED, $urandom, random_mac());
        send_request(arpc_pkg::REQ_CLEAR, $urandom, random_mac());
        // After a clear, old entries are unreachable and slot 0 is free again.
        send_request(arpc_pkg::REQ_LOOKUP, '1, random_mac());
        send_request(arpc_pkg::REQ_INSERT, 32'hC0A8_0105, random_mac());
        hold_until_drained();

        // Random part: addresses mostly from a small pool so that lookups hit.
        for (int k = 0; k < POOL_SIZE; k++) ip_pool[k] = $urandom;
        ip_pool[0] = '0;
        ip_pool[1] = '1;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 50 == 0) tx_burst = ($urandom_range(0, 3) == 0);
            if (n == RANDOM_ITEMS / 2) hold_until_drained();
            pick = $urandom_range(0, 99);
            if (pick < 56) code = arpc_pkg::REQ_LOOKUP;
            else if (pick < 96) code = arpc_pkg::REQ_INSERT;
            else if (pick < 98) code = arpc_pkg::REQ_CLEAR;
            else code = REQ_UNUSED;
            ip = ($urandom_range(0, 99) < 85) ? ip_pool[$urandom_range(0, POOL_SIZE - 1)]
                                               : $urandom;
            send_request(code, ip, random_mac());
        end

        // Drain, then allow for a late spurious result.
        hold_until_drained();
        repeat (arpc_pkg::TABLE_ENTRIES + 8) @(posedge i_clk);

        $display("Sent %0d requests (lookups, inserts, clears and the unused code).", sent);
        $display("Checked %0d results: %0d lookup hits, %0d inserts into a full table.",
                 checked, hits, full_inserts);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
